// ===== rtl/core/wsdf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsdf_pkg
// shared types and constants of the websocket frame deframer
// ----------------------------------------------------------------------------
package wsdf_pkg;

  localparam int LENGTH_BITS_DEF = 32;

  localparam logic [6:0] LEN7_EXT16 = 7'd126;
  localparam logic [6:0] LEN7_EXT64 = 7'd127;

  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;

  localparam logic [2:0] EXT16_BYTES_M1 = 3'd1;
  localparam logic [2:0] EXT64_BYTES_M1 = 3'd7;
  localparam logic [2:0] KEY_BYTES_M1   = 3'd3;

  typedef enum logic [2:0] {
    PH_HDR1   = 3'd0,
    PH_HDR2   = 3'd1,
    PH_EXT    = 3'd2,
    PH_MASK   = 3'd3,
    PH_PAY    = 3'd4,
    PH_CLOSED = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    ST_PAYLOAD    = 2'd0,
    ST_BAD_OPCODE = 2'd1,
    ST_TOO_LONG   = 2'd2
  } status_t;

endpackage

// ===== rtl/core/websocket_frame_deframer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// websocket_frame_deframer
// receive-side websocket frame parser, one stream byte per request
// ----------------------------------------------------------------------------
// the result of an accepted byte is registered in the output register
// throughput: one byte per cycle while in_stall is low, set by the single parse/unmask pass per byte
// the output register refills in the cycle its result is taken
// reset (synchronous, rst_n low) returns to the first header byte, reopens a
// closed stream and empties the output register
module websocket_frame_deframer #(
  parameter int LENGTH_BITS = wsdf_pkg::LENGTH_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_payload_byte,
  output logic       out_frame_fin,
  output logic [3:0] out_frame_opcode,
  output logic       out_last_of_frame,
  output logic [1:0] out_status
);
  import wsdf_pkg::*;

  phase_t                 phase_r, phase_nxt;
  logic [2:0]             ext_cnt_r, ext_cnt_nxt;
  logic [LENGTH_BITS-1:0] len_r, len_nxt;
  logic [31:0]            key_r, key_nxt;
  logic [1:0]             key_idx_r, key_idx_nxt;
  logic                   masked_r, masked_nxt;
  logic                   fin_r, fin_nxt;
  logic [3:0]             opcode_r, opcode_nxt;

  logic                   in_fire;
  logic                   res_valid;
  logic [7:0]             res_byte;
  logic                   res_last;
  status_t                res_status;
  logic [7:0]             key_byte;
  logic [LENGTH_BITS-1:0] len_dec;
  logic                   slot_free;

  logic                   out_valid_r;
  logic [7:0]             payload_r;
  logic                   fin_out_r;
  logic [3:0]             opcode_out_r;
  logic                   last_r;
  status_t                status_r;

  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = !slot_free;
  assign in_fire   = in_valid && slot_free;
  assign len_dec   = len_r - LENGTH_BITS'(1);

  always_comb begin
    case (key_idx_r)
      2'd0:    key_byte = key_r[31:24];
      2'd1:    key_byte = key_r[23:16];
      2'd2:    key_byte = key_r[15:8];
      default: key_byte = key_r[7:0];
    endcase
  end

  // next state
  always_comb begin
    phase_nxt   = phase_r;
    ext_cnt_nxt = ext_cnt_r;
    len_nxt     = len_r;
    key_nxt     = key_r;
    key_idx_nxt = key_idx_r;
    masked_nxt  = masked_r;
    fin_nxt     = fin_r;
    opcode_nxt  = opcode_r;
    if (in_fire) begin
      case (phase_r)
        PH_HDR1: begin
          fin_nxt    = in_byte[7];
          opcode_nxt = in_byte[3:0];
          if (in_byte[3:0] == OP_TEXT || in_byte[3:0] == OP_BINARY) begin
            phase_nxt = PH_HDR2;
          end else begin
            phase_nxt = PH_CLOSED;
          end
        end
        PH_HDR2: begin
          masked_nxt = in_byte[7];
          if (in_byte[6:0] == LEN7_EXT16) begin
            len_nxt     = '0;
            ext_cnt_nxt = EXT16_BYTES_M1;
            phase_nxt   = PH_EXT;
          end else if (in_byte[6:0] == LEN7_EXT64) begin
            len_nxt     = '0;
            ext_cnt_nxt = EXT64_BYTES_M1;
            phase_nxt   = PH_EXT;
          end else begin
            len_nxt     = LENGTH_BITS'(in_byte[6:0]);
            key_idx_nxt = '0;
            if (in_byte[7]) begin
              ext_cnt_nxt = KEY_BYTES_M1;
              key_nxt     = '0;
              phase_nxt   = PH_MASK;
            end else if (in_byte[6:0] == 7'd0) begin
              phase_nxt = PH_HDR1;
            end else begin
              phase_nxt = PH_PAY;
            end
          end
        end
        PH_EXT: begin
          // length would overflow its register: close the stream
          if (len_r[LENGTH_BITS-1 -: 8] != 8'd0) begin
            phase_nxt = PH_CLOSED;
          end else begin
            len_nxt = {len_r[LENGTH_BITS-9:0], in_byte};
            if (ext_cnt_r == 3'd0) begin
              key_idx_nxt = '0;
              if (masked_r) begin
                ext_cnt_nxt = KEY_BYTES_M1;
                key_nxt     = '0;
                phase_nxt   = PH_MASK;
              end else if ({len_r[LENGTH_BITS-9:0], in_byte} == '0) begin
                phase_nxt = PH_HDR1;
              end else begin
                phase_nxt = PH_PAY;
              end
            end else begin
              ext_cnt_nxt = ext_cnt_r - 3'd1;
            end
          end
        end
        PH_MASK: begin
          key_nxt = {key_r[23:0], in_byte};
          if (ext_cnt_r == 3'd0) begin
            key_idx_nxt = '0;
            phase_nxt   = (len_r == '0) ? PH_HDR1 : PH_PAY;
          end else begin
            ext_cnt_nxt = ext_cnt_r - 3'd1;
          end
        end
        PH_PAY: begin
          key_idx_nxt = key_idx_r + 2'd1;
          len_nxt     = len_dec;
          if (len_dec == '0) begin
            phase_nxt = PH_HDR1;
          end
        end
        default: begin
          phase_nxt = PH_CLOSED;
        end
      endcase
    end
  end

  // result of the current byte
  always_comb begin
    res_valid  = 1'b0;
    res_byte   = 8'd0;
    res_last   = 1'b0;
    res_status = ST_PAYLOAD;
    case (phase_r)
      PH_HDR1: begin
        if (!(in_byte[3:0] == OP_TEXT || in_byte[3:0] == OP_BINARY)) begin
          res_valid  = 1'b1;
          res_status = ST_BAD_OPCODE;
        end
      end
      PH_EXT: begin
        if (len_r[LENGTH_BITS-1 -: 8] != 8'd0) begin
          res_valid  = 1'b1;
          res_status = ST_TOO_LONG;
        end
      end
      PH_PAY: begin
        res_valid = 1'b1;
        res_byte  = masked_r ? (in_byte ^ key_byte) : in_byte;
        res_last  = (len_dec == '0);
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HDR1;
      ext_cnt_r   <= '0;
      len_r       <= '0;
      key_r       <= '0;
      key_idx_r   <= '0;
      masked_r    <= 1'b0;
      fin_r       <= 1'b0;
      opcode_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      ext_cnt_r   <= ext_cnt_nxt;
      len_r       <= len_nxt;
      key_r       <= key_nxt;
      key_idx_r   <= key_idx_nxt;
      masked_r    <= masked_nxt;
      fin_r       <= fin_nxt;
      opcode_r    <= opcode_nxt;
      if (slot_free) begin
        out_valid_r <= in_fire && res_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && res_valid) begin
      payload_r    <= res_byte;
      fin_out_r    <= fin_nxt;
      opcode_out_r <= opcode_nxt;
      last_r       <= res_last;
      status_r     <= res_status;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_payload_byte  = payload_r;
  assign out_frame_fin     = fin_out_r;
  assign out_frame_opcode  = opcode_out_r;
  assign out_last_of_frame = last_r;
  assign out_status        = status_r;

endmodule

// ===== dv/websocket_frame_deframer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// websocket_frame_deframer_tb
// self-checking bench for the websocket receive-side deframer: a byte stream
// of well-formed frames (short, 16-bit and 64-bit lengths, masked and plain,
// empty frames, frames of up to 320 bytes) is pushed through under random back-pressure,
// every result is checked against an in-bench parser, and the stream is
// closed at the end by a bad opcode or an oversized length
// ----------------------------------------------------------------------------
module websocket_frame_deframer_tb;
  import wsdf_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_AT      = 300;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 16;
  localparam int PRINT_CAP    = 40;

  // how the frame length is carried in the header
  localparam int FORM_SHORT = 0;
  localparam int FORM_EXT16 = 1;
  localparam int FORM_EXT64 = 2;

  typedef struct packed {
    logic [7:0] data;
    logic       fin;
    logic [3:0] opcode;
    logic       last;
    status_t    status;
  } frame_out_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_payload_byte;
  logic       out_frame_fin;
  logic [3:0] out_frame_opcode;
  logic       out_last_of_frame;
  logic [1:0] out_status;

  // parser state of the bench
  phase_t      prs_phase = PH_HDR1;
  logic [2:0]  ext_left = '0;
  logic [63:0] len_left = '0;
  logic [31:0] key_word = '0;
  logic [1:0]  key_idx = '0;
  logic        key_on = 1'b0;
  logic        fin_r = 1'b0;
  logic [3:0]  op_r = '0;
  logic        stream_closed = 1'b0;

  logic [7:0] rx_stream_q[$];
  frame_out_t deframed_q[$];
  frame_out_t want_r;

  int send_idle_pct = 7;
  int recv_idle_pct = 58;
  int bytes_taken = 0;
  int rx_hold_left = 0;
  bit rx_hold_done = 1'b0;
  int cycle_count = 0;
  int mismatch_count = 0;
  int results_checked = 0;
  int frames_queued = 0;
  string close_reason = "none";

  websocket_frame_deframer u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_byte          (in_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_payload_byte (out_payload_byte),
    .out_frame_fin    (out_frame_fin),
    .out_frame_opcode (out_frame_opcode),
    .out_last_of_frame(out_last_of_frame),
    .out_status       (out_status)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string field, input logic [7:0] got,
                                 input logic [7:0] want);
    if (mismatch_count < PRINT_CAP) begin
      $display("%0t: result %0d %s got %0h want %0h", $realtime, results_checked,
               field, got, want);
    end
    mismatch_count++;
  endtask

  // append a byte to the stream still to be sent
  function automatic void put_byte(input logic [7:0] b);
    rx_stream_q.insert(rx_stream_q.size(), b);
  endfunction

  // append a result to those still expected
  function automatic void put_result(input frame_out_t r);
    deframed_q.insert(deframed_q.size(), r);
  endfunction

  function automatic void close_stream(input status_t why);
    frame_out_t r;
    stream_closed = 1'b1;
    prs_phase = PH_CLOSED;
    r.data = '0;
    r.fin = fin_r;
    r.opcode = op_r;
    r.last = 1'b0;
    r.status = why;
    put_result(r);
  endfunction

  function automatic void length_complete();
    key_idx = '0;
    if (key_on) begin
      ext_left = KEY_BYTES_M1;
      key_word = '0;
      prs_phase = PH_MASK;
    end else if (len_left == 0) begin
      prs_phase = PH_HDR1;
    end else begin
      prs_phase = PH_PAY;
    end
  endfunction

  function automatic void deframe_byte(input logic [7:0] b);
    frame_out_t r;
    logic [7:0] k;
    if (stream_closed) return;
    case (prs_phase)
      PH_HDR2: begin
        key_on = b[7];
        len_left = '0;
        if (b[6:0] == LEN7_EXT16) begin
          ext_left = EXT16_BYTES_M1;
          prs_phase = PH_EXT;
        end else if (b[6:0] == LEN7_EXT64) begin
          ext_left = EXT64_BYTES_M1;
          prs_phase = PH_EXT;
        end else begin
          len_left = 64'(b[6:0]);
          length_complete();
        end
      end
      PH_EXT: begin
        // the next shift would drop length bits off the top of a LENGTH_BITS_DEF-bit length
        if ((len_left >> (LENGTH_BITS_DEF - 8)) != 0) begin
          close_stream(ST_TOO_LONG);
        end else begin
          len_left = {len_left[55:0], b};
          if (ext_left == 0) length_complete();
          else ext_left = ext_left - 3'd1;
        end
      end
      PH_MASK: begin
        key_word = {key_word[23:0], b};
        if (ext_left == 0) begin
          key_idx = '0;
          prs_phase = (len_left == 0) ? PH_HDR1 : PH_PAY;
        end else begin
          ext_left = ext_left - 3'd1;
        end
      end
      PH_PAY: begin
        k = key_on ? key_word[8 * (3 - key_idx) +: 8] : 8'h00;
        key_idx = key_idx + 2'd1;
        len_left = len_left - 64'd1;
        r.data = b ^ k;
        r.fin = fin_r;
        r.opcode = op_r;
        r.last = (len_left == 0);
        r.status = ST_PAYLOAD;
        if (r.last) prs_phase = PH_HDR1;
        put_result(r);
      end
      default: begin
        fin_r = b[7];
        op_r = b[3:0];
        if (op_r != OP_TEXT && op_r != OP_BINARY) close_stream(ST_BAD_OPCODE);
        else prs_phase = PH_HDR2;
      end
    endcase
  endfunction

  task automatic queue_frame(input logic [7:0] hdr1, input bit masked, input int form,
                             input int unsigned len);
    logic [63:0] len64;
    len64 = 64'(len);
    put_byte(hdr1);
    case (form)
      FORM_SHORT: begin
        put_byte({masked, len64[6:0]});
      end
      FORM_EXT16: begin
        put_byte({masked, LEN7_EXT16});
        put_byte(len64[15:8]);
        put_byte(len64[7:0]);
      end
      default: begin
        put_byte({masked, LEN7_EXT64});
        for (int i = 7; i >= 0; i--) put_byte(len64[8 * i +: 8]);
      end
    endcase
    if (masked) repeat (4) put_byte(8'($urandom));
    repeat (len) put_byte(8'($urandom));
    frames_queued++;
  endtask

  task automatic queue_random_bytes(input int unsigned n_bytes);
    logic [7:0] hdr1;
    bit masked;
    int form;
    int unsigned len;
    int unsigned r;
    while (rx_stream_q.size() < n_bytes) begin
      hdr1 = {1'($urandom_range(1)), 3'($urandom_range(7)),
              $urandom_range(1) ? OP_TEXT : OP_BINARY};
      masked = ($urandom_range(99) < 60);
      r = $urandom_range(99);
      form = (r < 70) ? FORM_SHORT : (r < 85) ? FORM_EXT16 : FORM_EXT64;
      r = $urandom_range(99);
      if (r < 8) len = 0;
      else if (r < 14) len = (form == FORM_SHORT) ? 125 : $urandom_range(320, 256);
      else len = $urandom_range(24, 1);
      queue_frame(hdr1, masked, form, len);
    end
  endtask

  // ends the stream for good: nothing after this yields a result
  task automatic queue_close();
    logic [3:0] op;
    int k;
    if ($urandom_range(1)) begin
      close_reason = "bad opcode";
      op = 4'($urandom_range(13));
      if (op >= OP_TEXT) op = op + 4'd2;
      put_byte({1'($urandom_range(1)), 3'($urandom_range(7)), op});
    end else begin
      close_reason = "oversized length";
      put_byte({1'($urandom_range(1)), 3'($urandom_range(7)),
                $urandom_range(1) ? OP_TEXT : OP_BINARY});
      put_byte({1'($urandom_range(1)), LEN7_EXT64});
      k = $urandom_range(3);
      for (int i = 0; i < 8; i++) begin
        if (i < k) put_byte(8'h00);
        else if (i == k) put_byte(8'($urandom_range(255, 1)));
        else put_byte(8'($urandom));
      end
    end
    repeat (24) put_byte(8'($urandom));
  endtask

  task automatic wait_drained();
    while (rx_stream_q.size() != 0 || in_valid || deframed_q.size() != 0) @(negedge clk);
  endtask

  // sender: one request per accepted byte, held steady while stalled
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        deframe_byte(in_byte);
        void'(rx_stream_q.pop_front());
        bytes_taken <= bytes_taken + 1;
      end
      if (!in_valid || !in_stall) begin
        if (rx_stream_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_byte <= rx_stream_q[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // one long output hold-off while the sender keeps offering
  always @(posedge clk) begin
    if (!rst_n) begin
      rx_hold_left <= 0;
      rx_hold_done <= 1'b0;
    end else if (rx_hold_left != 0) begin
      rx_hold_left <= rx_hold_left - 1;
    end else if (!rx_hold_done && bytes_taken >= HOLD_AT) begin
      rx_hold_left <= HOLD_CYCLES;
      rx_hold_done <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (deframed_q.size() == 0) begin
          report_mismatch("unexpected result, payload_byte", out_payload_byte, 8'h00);
        end else begin
          want_r = deframed_q.pop_front();
          if (out_payload_byte !== want_r.data)
            report_mismatch("payload_byte", out_payload_byte, want_r.data);
          if (out_frame_fin !== want_r.fin)
            report_mismatch("frame_fin", 8'(out_frame_fin), 8'(want_r.fin));
          if (out_frame_opcode !== want_r.opcode)
            report_mismatch("frame_opcode", 8'(out_frame_opcode), 8'(want_r.opcode));
          if (out_last_of_frame !== want_r.last)
            report_mismatch("last_of_frame", 8'(out_last_of_frame), 8'(want_r.last));
          if (out_status !== want_r.status)
            report_mismatch("status", 8'(out_status), 8'(want_r.status));
        end
        results_checked++;
      end
      out_stall <= (rx_hold_left != 0) || ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               deframed_q.size());
      $display("websocket_frame_deframer_tb: errors");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // plain text frame with extreme payload bytes
    put_byte({1'b1, 3'b000, OP_TEXT});
    put_byte({1'b0, 7'd2});
    put_byte(8'h00);
    put_byte(8'hFF);
    // empty frames, masked and plain
    queue_frame({1'b0, 3'b000, OP_BINARY}, 1'b1, FORM_SHORT, 0);
    queue_frame({1'b0, 3'b111, OP_BINARY}, 1'b0, FORM_SHORT, 0);
    // key index wraps past the fourth byte
    queue_frame({1'b1, 3'b101, OP_TEXT}, 1'b1, FORM_SHORT, 5);
    // non-minimal 16-bit length
    queue_frame({1'b1, 3'b010, OP_BINARY}, 1'b0, FORM_EXT16, 1);
    wait_drained();

    send_idle_pct = 7;
    recv_idle_pct = 58;
    queue_random_bytes(610);
    wait_drained();

    send_idle_pct = 58;
    recv_idle_pct = 7;
    queue_random_bytes(610);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random_bytes(410);
    // non-minimal 64-bit length
    queue_frame({1'b1, 3'b000, OP_BINARY}, 1'b1, FORM_EXT64, 3);
    queue_random_bytes(rx_stream_q.size() + 200);
    queue_close();
    wait_drained();

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (deframed_q.size() != 0)
      report_mismatch("results never seen", 8'(deframed_q.size()), 8'h00);

    $display("%0d frames over %0d stream bytes, %0d results checked, %0d mismatches",
             frames_queued, bytes_taken, results_checked, mismatch_count);
    $display("stream closed by %s under mixed sender and receiver back-pressure",
             close_reason);
    if (mismatch_count == 0) begin
      $display("websocket_frame_deframer_tb: clean");
    end else begin
      $display("websocket_frame_deframer_tb: errors");
    end
    $finish;
  end

endmodule
